FILE: hw/rtl/smn_pkg.sv
// ----------------------------------------------------------------------------
// smn_pkg
// Widths, step counts and state encoding shared by the spectrum magnitude
// normalizer and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package smn_pkg;

  localparam int unsigned BIN_W    = 24;
  localparam int unsigned SQ_W     = 2 * BIN_W;
  localparam int unsigned MAG_W    = 24;
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned REM_W    = MAG_W + 1;
  localparam int unsigned STEP_W   = 5;

  localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(MAG_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(LEVEL_W - 1);

  typedef logic signed [BIN_W-1:0] bin_t;
  typedef logic [MAG_W-1:0]        mag_t;
  typedef logic [LEVEL_W-1:0]      level_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_RE,
    S_SQ_IM,
    S_SUM,
    S_ROOT,
    S_STORE,
    S_FETCH,
    S_LOAD,
    S_DIV,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/smn_in_if.sv
// ----------------------------------------------------------------------------
// smn_in_if
// Spectrum bin channel: valid/ready with signed real and imaginary parts.
// ----------------------------------------------------------------------------
`default_nettype none

interface smn_in_if
  import smn_pkg::*;
;
  logic valid;
  logic ready;
  bin_t bin_real;
  bin_t bin_imag;

  modport source (output valid, output bin_real, output bin_imag, input ready);
  modport sink   (input valid, input bin_real, input bin_imag, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/smn_out_if.sv
// ----------------------------------------------------------------------------
// smn_out_if
// Level channel: valid/ready with a 12-bit level and a last-bin marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface smn_out_if
  import smn_pkg::*;
;
  logic   valid;
  logic   ready;
  level_t level;
  logic   last_bin;

  modport source (output valid, output level, output last_bin, input ready);
  modport sink   (input valid, input level, input last_bin, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/spectrum_magnitude_normalizer.sv
// ----------------------------------------------------------------------------
// spectrum_magnitude_normalizer
// Bin magnitude, peak tracking and peak-relative level output per frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one spectrum bin per transfer (signed 24-bit real and imaginary).
//   out_ch : NUM_BINS levels per frame, floor(4095 * mag / peak), last_bin set
//            on the final level. A zero peak gives all-zero levels.
//   Each bin, from its transfer to the next possible one, passes through
//   the real and the imaginary square on the shared 24x24 squaring
//   multiplier, the sum, the bit-pair serial square root, the magnitude
//   memory write and a return to idle with in_ch.ready high.
//   After the last bin of a frame, in_ch.ready stays low while the levels
//   go out. Each level then passes through the memory read, numerator
//   setup, the bit-serial divider and an output state that holds
//   out_ch.valid high until the receiver takes the level.
//   A stalled receiver holds out_ch.valid and the level; nothing is dropped.
//   Reset (rst_n low, synchronous) empties the frame and clears the peak;
//   the magnitude memory is not cleared and needs no pass.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_magnitude_normalizer
  import smn_pkg::*;
#(
  parameter int unsigned NUM_BINS = 64
) (
  input  wire        clk,
  input  wire        rst_n,
  smn_in_if.sink     in_ch,
  smn_out_if.source  out_ch
);

  localparam int unsigned AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BINS - 1);

  state_t state_r, state_nxt;

  logic [BIN_W-1:0]  re_abs_r, im_abs_r;
  logic [SQ_W-1:0]   prod_r, sq_r, rad_r;
  logic [REM_W-1:0]  rem_r;
  mag_t              root_r;
  logic [STEP_W-1:0] step_r;
  logic [AW-1:0]     bin_cnt_r, rd_idx_r;
  mag_t              peak_r, div_r, rd_data_r;
  logic [MAG_W-1:0]  drem_r;
  level_t            nlo_r, quo_r;
  logic              last_r;

  mag_t mag_mem_r [NUM_BINS];

  logic [BIN_W-1:0]     mul_op;
  logic [SQ_W-1:0]      mul_out;
  logic [REM_W+1:0]     root_rem_sh, root_trial;
  logic                 root_ge;
  logic [MAG_W+LEVEL_W-1:0] num;
  logic [MAG_W:0]       div_rem_sh;
  logic                 div_ge;

  // shared squaring multiplier
  assign mul_op  = (state_r == S_SQ_RE) ? re_abs_r : im_abs_r;
  assign mul_out = SQ_W'(mul_op) * SQ_W'(mul_op);

  // square root step: two radicand bits per cycle
  assign root_rem_sh = {rem_r, rad_r[SQ_W-1 -: 2]};
  assign root_trial  = {1'b0, root_r, 2'b01};
  assign root_ge     = (root_rem_sh >= root_trial);

  // mag * 4095
  assign num = {rd_data_r, {LEVEL_W{1'b0}}} - (MAG_W + LEVEL_W)'(rd_data_r);

  // division step: one quotient bit per cycle
  assign div_rem_sh = {drem_r, nlo_r[LEVEL_W-1]};
  assign div_ge     = (div_rem_sh >= {1'b0, div_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_SQ_RE;
      S_SQ_RE: state_nxt = S_SQ_IM;
      S_SQ_IM: state_nxt = S_SUM;
      S_SUM:   state_nxt = S_ROOT;
      S_ROOT:  if (step_r == ROOT_LAST) state_nxt = S_STORE;
      S_STORE: state_nxt = (bin_cnt_r == LAST_IDX) ? S_FETCH : S_IDLE;
      S_FETCH: state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_DIV;
      S_DIV:   if (step_r == DIV_LAST) state_nxt = S_OUT;
      S_OUT: begin
        if (out_ch.ready) state_nxt = (rd_idx_r == LAST_IDX) ? S_IDLE : S_FETCH;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready     = 1'b0;
    out_ch.valid    = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ch.ready  = 1'b1;
      S_OUT:   out_ch.valid = 1'b1;
      default: ;
    endcase
  end

  assign out_ch.level    = quo_r;
  assign out_ch.last_bin = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // frame control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r <= '0;
      peak_r    <= '0;
      rd_idx_r  <= '0;
    end else begin
      case (state_r)
        S_STORE: begin
          if (root_r > peak_r) peak_r <= root_r;
          bin_cnt_r <= (bin_cnt_r == LAST_IDX) ? '0 : bin_cnt_r + 1'b1;
          rd_idx_r  <= '0;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            rd_idx_r <= rd_idx_r + 1'b1;
            if (rd_idx_r == LAST_IDX) peak_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        re_abs_r <= in_ch.bin_real[BIN_W-1] ? (~in_ch.bin_real + 1'b1) : in_ch.bin_real;
        im_abs_r <= in_ch.bin_imag[BIN_W-1] ? (~in_ch.bin_imag + 1'b1) : in_ch.bin_imag;
      end
      S_SQ_RE: prod_r <= mul_out;
      S_SQ_IM: begin
        sq_r   <= prod_r;
        prod_r <= mul_out;
      end
      S_SUM: begin
        rad_r  <= sq_r + prod_r;
        rem_r  <= '0;
        root_r <= '0;
        step_r <= '0;
      end
      S_ROOT: begin
        rad_r  <= {rad_r[SQ_W-3:0], 2'b00};
        rem_r  <= root_ge ? REM_W'(root_rem_sh - root_trial) : REM_W'(root_rem_sh);
        root_r <= {root_r[MAG_W-2:0], root_ge};
        step_r <= step_r + 1'b1;
      end
      S_FETCH: div_r <= (peak_r == '0) ? MAG_W'(1) : peak_r;
      S_LOAD: begin
        drem_r <= num[MAG_W+LEVEL_W-1:LEVEL_W];
        nlo_r  <= num[LEVEL_W-1:0];
        step_r <= '0;
        last_r <= (rd_idx_r == LAST_IDX);
      end
      S_DIV: begin
        drem_r <= div_ge ? MAG_W'(div_rem_sh - {1'b0, div_r}) : MAG_W'(div_rem_sh);
        nlo_r  <= {nlo_r[LEVEL_W-2:0], 1'b0};
        quo_r  <= {quo_r[LEVEL_W-2:0], div_ge};
        step_r <= step_r + 1'b1;
      end
      default: ;
    endcase
  end

  // magnitude memory
  always_ff @(posedge clk) begin
    if (state_r == S_STORE) mag_mem_r[bin_cnt_r] <= root_r;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mag_mem_r[rd_idx_r];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/smn_checker.sv
// ----------------------------------------------------------------------------
// smn_checker
// Port-level checks on the spectrum magnitude normalizer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module smn_checker
  import smn_pkg::*;
(
  input wire    clk,
  input wire    rst_n,
  input wire    in_valid,
  input wire    in_ready,
  input wire    out_valid,
  input wire    out_ready,
  input level_t out_level,
  input wire    out_last_bin
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_last_bin))
    else $error("stalled level changed");

  // no bin taken while levels go out
  a_no_overlap: assert property (@(posedge clk) !(in_ready && out_valid))
    else $error("input ready during output");

  // a bin transfer starts a multi-cycle computation
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("ready right after bin transfer");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind spectrum_magnitude_normalizer smn_checker u_smn_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_level    (out_ch.level),
  .out_last_bin (out_ch.last_bin)
);

`default_nettype wire

FILE: dv/smn_level_checker.sv
// ----------------------------------------------------------------------------
// smn_level_checker
// Watches both channels of the spectrum magnitude normalizer. Every bin
// transfer updates a local frame (floor square root magnitude, running
// peak); the frame's final bin queues NUM_BINS expected levels, and each
// level transfer is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module smn_level_checker
  import smn_pkg::*;
#(
  parameter int unsigned NUM_BINS = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  smn_in_if           in_mon,
  smn_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  localparam longint unsigned FULL_SCALE = 4095;

  typedef struct packed {
    level_t level;
    logic   last_bin;
  } level_item_t;

  mag_t        frame_mags [NUM_BINS];
  mag_t        frame_peak;
  int unsigned frame_fill;
  int unsigned failures;
  level_item_t expected_levels [$];

  // Greedy bit-by-bit floor square root of re^2 + im^2.
  function automatic mag_t bin_magnitude(bin_t re, bin_t im);
    longint          re_w;
    longint          im_w;
    longint unsigned power;
    longint unsigned root;
    longint unsigned trial;
    re_w  = re;
    im_w  = im;
    power = longint'(re_w * re_w) + longint'(im_w * im_w);
    root  = 0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= power) begin
        root = trial;
      end
    end
    return mag_t'(root);
  endfunction

  function automatic level_t scaled_level(mag_t mag, mag_t peak);
    longint unsigned numer;
    longint unsigned divisor;
    numer   = longint'(mag) * FULL_SCALE;
    divisor = (peak == '0) ? 64'd1 : longint'(peak);
    return level_t'(numer / divisor);
  endfunction

  always @(posedge clk) begin : watch
    level_item_t want;
    mag_t        mag;
    if (!rst_n) begin
      frame_fill = 0;
      frame_peak = '0;
      failures   = 0;
      expected_levels.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_levels.size() == 0) begin
          $display("%0t: unexpected level transfer: level %0d last_bin %0b",
                   $time, out_mon.level, out_mon.last_bin);
          failures++;
        end else begin
          want = expected_levels.pop_front();
          if (out_mon.level !== want.level) begin
            $display("%0t: level mismatch: expected %0d, actual %0d",
                     $time, want.level, out_mon.level);
            failures++;
          end
          if (out_mon.last_bin !== want.last_bin) begin
            $display("%0t: last_bin mismatch: expected %0b, actual %0b",
                     $time, want.last_bin, out_mon.last_bin);
            failures++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        mag = bin_magnitude(in_mon.bin_real, in_mon.bin_imag);
        frame_mags[frame_fill] = mag;
        if (mag > frame_peak) begin
          frame_peak = mag;
        end
        frame_fill++;
        if (frame_fill == NUM_BINS) begin
          for (int k = 0; k < NUM_BINS; k++) begin
            want.level    = scaled_level(frame_mags[k], frame_peak);
            want.last_bin = (k == NUM_BINS - 1);
            expected_levels.push_back(want);
          end
          frame_fill = 0;
          frame_peak = '0;
        end
      end
    end
    fail_count  <= failures;
    outstanding <= expected_levels.size();
  end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives spectrum bins into the magnitude normalizer and drains its levels:
// directed extremes first, then frames of full-range, all-zero, small and
// mixed bins, a trailing partial frame, random idling on both channels, a
// long receiver hold-off and a drain pause. The checker gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import smn_pkg::*;

  localparam int unsigned BINS         = 64;
  localparam int unsigned TOTAL_BINS   = 4 * BINS + 14;
  localparam int unsigned CALM_TAIL    = 40;
  localparam int unsigned HOLD_AT      = 170;
  localparam int unsigned HOLD_CYCLES  = 2000;
  localparam int unsigned SETTLE       = 200;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DIRECTED_NUM = 24;

  typedef enum int unsigned {PART_ZERO, PART_SMALL, PART_FULL} part_kind_t;

  logic        clk;
  logic        rst_n;
  logic        hold_armed;
  logic        calm;
  int unsigned level_failures;
  int unsigned levels_outstanding;

  bin_t directed_re [DIRECTED_NUM] = '{
    24'h000000, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
    24'h000000, 24'h7FFFFF, 24'h000000, 24'h000001, 24'h000000, 24'hFFFFFF,
    24'h000000, 24'hFFFFFF, 24'h000001, 24'h000003, 24'hFFFFFD, 24'h000005,
    24'h000002, 24'h555555, 24'hAAAAAA, 24'h000FFF, 24'h001000, 24'h3FFFFF
  };
  bin_t directed_im [DIRECTED_NUM] = '{
    24'h000000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h000000,
    24'h800000, 24'h000000, 24'h7FFFFF, 24'h000000, 24'h000001, 24'h000000,
    24'hFFFFFF, 24'hFFFFFF, 24'h000001, 24'h000004, 24'hFFFFFC, 24'h00000C,
    24'h000002, 24'hAAAAAA, 24'h555555, 24'h000000, 24'h000000, 24'hC00000
  };

  smn_in_if  in_ch ();
  smn_out_if out_ch ();

  spectrum_magnitude_normalizer #(
    .NUM_BINS (BINS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  smn_level_checker #(
    .NUM_BINS (BINS)
  ) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (level_failures),
    .outstanding (levels_outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic bin_t pick_part(part_kind_t kind);
    int v;
    case (kind)
      PART_ZERO: begin
        v = 0;
      end
      PART_SMALL: begin
        v = int'($urandom_range(0, 2048)) - 1024;
      end
      default: begin
        v = int'($urandom());
      end
    endcase
    return bin_t'(v);
  endfunction

  function automatic part_kind_t frame_kind(int unsigned n);
    case (n / BINS)
      1: begin
        return PART_ZERO;
      end
      2: begin
        return PART_SMALL;
      end
      3: begin
        return part_kind_t'($urandom_range(PART_ZERO, PART_FULL));
      end
      default: begin
        return PART_FULL;
      end
    endcase
  endfunction

  task automatic send_bin(input bin_t re, input bin_t im);
    in_ch.valid    <= 1'b1;
    in_ch.bin_real <= re;
    in_ch.bin_imag <= im;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  initial begin : level_receiver
    int unsigned span;
    bit          hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        out_ch.ready <= 1'b0;
        hold_done = 1'b1;
        span = 0;
        while (span < HOLD_CYCLES) begin
          @(posedge clk);
          span++;
        end
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : bin_source
    part_kind_t kind;
    bin_t       re;
    bin_t       im;
    in_ch.valid    <= 1'b0;
    in_ch.bin_real <= '0;
    in_ch.bin_imag <= '0;
    hold_armed     <= 1'b0;
    calm           <= 1'b0;
    do @(posedge clk); while (!rst_n);
    for (int unsigned n = 0; n < TOTAL_BINS; n++) begin
      if (n < DIRECTED_NUM) begin
        re = directed_re[n];
        im = directed_im[n];
      end else begin
        kind = frame_kind(n);
        re   = pick_part(kind);
        im   = pick_part(kind);
      end
      send_bin(re, im);
      if (n == HOLD_AT) begin
        hold_armed <= 1'b1;
      end
      if (n + CALM_TAIL == TOTAL_BINS) begin
        calm <= 1'b1;
      end
      if (n == BINS - 1) begin
        // let the first frame drain completely before the next bin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (levels_outstanding == 0);
        @(posedge clk);
      end else if (n + CALM_TAIL < TOTAL_BINS && $urandom_range(0, 3) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (levels_outstanding == 0);
    repeat (SETTLE) @(posedge clk);
    if (level_failures == 0 && levels_outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/smn_pkg.sv
hw/rtl/smn_in_if.sv
hw/rtl/smn_out_if.sv
hw/rtl/spectrum_magnitude_normalizer.sv
hw/rtl/smn_checker.sv
dv/smn_level_checker.sv
dv/tb.sv
